@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the command decoder RTL.
// Every macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every sampled clock edge.
`define OCD_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// When the antecedent holds, the consequent must hold in the same cycle.
`define OCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/ocd_pkg.sv @@
// Package of the OLED command decoder: opcodes, operation classes, timing slots,
// reset values and the queue entry type. No dependencies.
`timescale 1ns / 1ps

package ocd_pkg;

  localparam int unsigned COLUMNS_DFLT = 128;
  localparam int unsigned PAGES_DFLT   = 8;
  localparam int unsigned QUEUE_DEPTH  = 2;

  // Opcodes that collect argument bytes, and the no-operation opcode.
  localparam logic [7:0] OPC_ADDR_MODE   = 8'h20;
  localparam logic [7:0] OPC_COL_WINDOW  = 8'h21;
  localparam logic [7:0] OPC_PAGE_WINDOW = 8'h22;
  localparam logic [7:0] OPC_CONTRAST    = 8'h81;
  localparam logic [7:0] OPC_PUMP        = 8'h8D;
  localparam logic [7:0] OPC_MUX         = 8'hA8;
  localparam logic [7:0] OPC_OFFSET      = 8'hD3;
  localparam logic [7:0] OPC_CLOCK       = 8'hD5;
  localparam logic [7:0] OPC_PRECHARGE   = 8'hD9;
  localparam logic [7:0] OPC_COM_PINS    = 8'hDA;
  localparam logic [7:0] OPC_VCOMH       = 8'hDB;
  localparam logic [7:0] OPC_NOP         = 8'hE3;

  // Addressing modes.
  localparam logic [1:0] MODE_HORIZONTAL = 2'd0;
  localparam logic [1:0] MODE_VERTICAL   = 2'd1;
  localparam logic [1:0] MODE_PAGE       = 2'd2;
  localparam logic [1:0] MODE_RESERVED   = 2'd3;

  // Timing register slots.
  localparam int unsigned TIMING_SLOTS = 7;
  localparam logic [2:0] SLOT_MUX       = 3'd0;
  localparam logic [2:0] SLOT_OFFSET    = 3'd1;
  localparam logic [2:0] SLOT_CLOCK     = 3'd2;
  localparam logic [2:0] SLOT_PRECHARGE = 3'd3;
  localparam logic [2:0] SLOT_COM_PINS  = 3'd4;
  localparam logic [2:0] SLOT_VCOMH     = 3'd5;
  localparam logic [2:0] SLOT_PUMP      = 3'd6;

  localparam logic [7:0] TIMING_RESET [TIMING_SLOTS] =
    '{8'h3F, 8'h00, 8'h80, 8'h22, 8'h12, 8'h20, 8'h10};

  localparam logic [7:0] CONTRAST_RESET = 8'h7F;

  // Operation classes handed from the front end to the back end.
  typedef enum logic [4:0] {
    OP_NONE,
    OP_DATA,
    OP_COL_LO,
    OP_COL_HI,
    OP_START_LINE,
    OP_REMAP,
    OP_ALL_LIT,
    OP_INVERT,
    OP_DISPLAY,
    OP_PAGE_SET,
    OP_SCAN,
    OP_BAD,
    OP_ARG_MODE,
    OP_ARG_COL_FIRST,
    OP_ARG_COL_LAST,
    OP_ARG_PAGE_FIRST,
    OP_ARG_PAGE_LAST,
    OP_ARG_CONTRAST,
    OP_ARG_TIMING
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [7:0] arg;
    logic [2:0] slot;
  } op_entry_t;

  // Returns {hit, slot} for opcodes that load a timing register.
  function automatic logic [3:0] timing_slot(input logic [7:0] opc);
    logic [3:0] res;
    res = '0;
    unique case (opc)
      OPC_MUX:       res = {1'b1, SLOT_MUX};
      OPC_OFFSET:    res = {1'b1, SLOT_OFFSET};
      OPC_CLOCK:     res = {1'b1, SLOT_CLOCK};
      OPC_PRECHARGE: res = {1'b1, SLOT_PRECHARGE};
      OPC_COM_PINS:  res = {1'b1, SLOT_COM_PINS};
      OPC_VCOMH:     res = {1'b1, SLOT_VCOMH};
      OPC_PUMP:      res = {1'b1, SLOT_PUMP};
      default:       res = '0;
    endcase
    return res;
  endfunction

endpackage

@@ rtl/core/ocd_cmd_if.sv @@
// Input channel of the OLED command decoder: one host byte per transaction.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface ocd_cmd_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] bus_byte;

  modport source (output valid, output kind, output bus_byte, input ready);
  modport sink   (input valid, input kind, input bus_byte, output ready);
endinterface

@@ rtl/core/ocd_res_if.sv @@
// Result channel of the OLED command decoder: RAM write and panel settings.
// Stand-alone interface, no dependencies.
`timescale 1ns / 1ps

interface ocd_res_if;
  logic       valid;
  logic       ready;
  logic       ram_write;
  logic [2:0] ram_page;
  logic [6:0] ram_column;
  logic [7:0] ram_data;
  logic       panel_on;
  logic       invert_pixels;
  logic       all_pixels_lit;
  logic [7:0] contrast_level;
  logic [5:0] first_line;
  logic       mirror_columns;
  logic       scan_reversed;
  logic       bad_opcode;

  modport source (
    output valid, input ready,
    output ram_write, output ram_page, output ram_column, output ram_data,
    output panel_on, output invert_pixels, output all_pixels_lit,
    output contrast_level, output first_line, output mirror_columns,
    output scan_reversed, output bad_opcode
  );
  modport sink (
    input valid, output ready,
    input ram_write, input ram_page, input ram_column, input ram_data,
    input panel_on, input invert_pixels, input all_pixels_lit,
    input contrast_level, input first_line, input mirror_columns,
    input scan_reversed, input bad_opcode
  );
endinterface

@@ rtl/core/ocd_queue.sv @@
// Small register FIFO that decouples the decoder front end from its back end.
// Depends on ocd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ocd_queue #(
  parameter int unsigned DEPTH = ocd_pkg::QUEUE_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  ocd_pkg::op_entry_t  push_entry_i,
  output logic                full_o,
  input  logic                pop_i,
  output logic                valid_o,
  output ocd_pkg::op_entry_t  head_o
);
  import ocd_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  op_entry_t         slots_q [DEPTH];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;
  logic              do_push, do_pop;

  assign full_o  = (count_q == CntW'(DEPTH));
  assign valid_o = (count_q != '0);
  assign head_o  = slots_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
    return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slots_q[wr_ptr_q] <= push_entry_i;
    end
  end

  `OCD_ASSERT(a_count_bound, count_q <= CntW'(DEPTH), "queue count exceeds depth")
  `OCD_ASSERT_IMPL(a_no_push_full, full_o, !do_push, "push accepted while full")
  `OCD_ASSERT_IMPL(a_ptrs_meet, count_q == '0, wr_ptr_q == rd_ptr_q,
                   "empty queue with pointers apart")

endmodule

@@ rtl/core/ocd_front.sv @@
// Front end of the OLED command decoder: accepts host bytes, tracks pending
// argument bytes and classifies each byte into an operation. Depends on ocd_pkg and ocd_cmd_if.
`timescale 1ns / 1ps

module ocd_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  ocd_cmd_if.sink            cmd_i,
  input  logic               q_full_i,
  output logic               push_o,
  output ocd_pkg::op_entry_t push_entry_o
);
  import ocd_pkg::*;

  logic [7:0] pend_q, pend_d;
  logic [1:0] args_q, args_d;
  logic [3:0] slot_hit;
  logic [3:0] pend_slot;
  logic       last_arg;
  logic [7:0] b;

  assign cmd_i.ready = !q_full_i;
  assign push_o      = cmd_i.valid && !q_full_i;
  assign b           = cmd_i.bus_byte;
  assign slot_hit    = timing_slot(b);
  assign pend_slot   = timing_slot(pend_q);
  assign last_arg    = (args_q == 2'd1);

  always_comb begin
    pend_d            = pend_q;
    args_d            = args_q;
    push_entry_o.op   = OP_NONE;
    push_entry_o.arg  = b;
    push_entry_o.slot = pend_slot[2:0];

    if (cmd_i.kind) begin
      // A data byte drops any command still waiting for arguments.
      args_d          = '0;
      push_entry_o.op = OP_DATA;
    end else if (args_q != '0) begin
      args_d = args_q - 2'd1;
      if (pend_q == OPC_ADDR_MODE) begin
        push_entry_o.op = OP_ARG_MODE;
      end else if (pend_q == OPC_COL_WINDOW) begin
        push_entry_o.op = last_arg ? OP_ARG_COL_LAST : OP_ARG_COL_FIRST;
      end else if (pend_q == OPC_PAGE_WINDOW) begin
        push_entry_o.op = last_arg ? OP_ARG_PAGE_LAST : OP_ARG_PAGE_FIRST;
      end else if (pend_q == OPC_CONTRAST) begin
        push_entry_o.op = OP_ARG_CONTRAST;
      end else if (pend_slot[3]) begin
        push_entry_o.op = OP_ARG_TIMING;
      end
    end else begin
      priority if (b <= 8'h0F) begin
        push_entry_o.op = OP_COL_LO;
      end else if (b <= 8'h1F) begin
        push_entry_o.op = OP_COL_HI;
      end else if (b == OPC_COL_WINDOW || b == OPC_PAGE_WINDOW) begin
        pend_d = b;
        args_d = 2'd2;
      end else if (b == OPC_ADDR_MODE || b == OPC_CONTRAST || slot_hit[3]) begin
        pend_d = b;
        args_d = 2'd1;
      end else if (b >= 8'h40 && b <= 8'h7F) begin
        push_entry_o.op = OP_START_LINE;
      end else if (b[7:1] == 7'h50) begin
        push_entry_o.op = OP_REMAP;
      end else if (b[7:1] == 7'h52) begin
        push_entry_o.op = OP_ALL_LIT;
      end else if (b[7:1] == 7'h53) begin
        push_entry_o.op = OP_INVERT;
      end else if (b[7:1] == 7'h57) begin
        push_entry_o.op = OP_DISPLAY;
      end else if (b[7:3] == 5'h16) begin
        push_entry_o.op = OP_PAGE_SET;
      end else if (b[7:4] == 4'hC) begin
        push_entry_o.op = OP_SCAN;
      end else if (b == OPC_NOP) begin
        push_entry_o.op = OP_NONE;
      end else begin
        push_entry_o.op = OP_BAD;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      args_q <= '0;
    end else if (push_o) begin
      pend_q <= pend_d;
      args_q <= args_d;
    end
  end

endmodule

@@ rtl/core/ocd_back.sv @@
// Back end of the OLED command decoder: executes classified operations on the
// address and panel state and registers one result per operation.
// Depends on ocd_pkg, ocd_res_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ocd_back #(
  parameter int unsigned COLUMNS = ocd_pkg::COLUMNS_DFLT,
  parameter int unsigned PAGES   = ocd_pkg::PAGES_DFLT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               q_valid_i,
  input  ocd_pkg::op_entry_t q_head_i,
  output logic               q_pop_o,
  ocd_res_if.source          res_o
);
  import ocd_pkg::*;

  localparam logic [6:0] ColMax  = 7'(COLUMNS - 1);
  localparam logic [2:0] PageMax = 3'(PAGES - 1);

  typedef struct packed {
    logic       ram_write;
    logic [2:0] ram_page;
    logic [6:0] ram_column;
    logic [7:0] ram_data;
    logic       bad_opcode;
  } write_res_t;

  logic [1:0] mode_q, mode_d;
  logic [6:0] col_first_q, col_first_d, col_last_q, col_last_d, col_ptr_q, col_ptr_d;
  logic [2:0] page_first_q, page_first_d, page_last_q, page_last_d, page_ptr_q, page_ptr_d;
  logic [7:0] contrast_q, contrast_d;
  logic       on_q, on_d, invert_q, invert_d, lit_q, lit_d, remap_q, remap_d;
  logic       scan_q, scan_d;
  logic [5:0] start_q, start_d;
  logic [7:0] timing_q [TIMING_SLOTS];
  logic       timing_we;

  write_res_t wres_d, wres_q;
  logic       out_valid_q;

  logic       col_end, page_end;
  logic [6:0] col_inc;
  logic [2:0] page_inc;
  logic [7:0] arg;

  function automatic logic [6:0] clamp_col(input logic [6:0] v);
    return (v > ColMax) ? ColMax : v;
  endfunction

  function automatic logic [2:0] clamp_page(input logic [2:0] v);
    return (v > PageMax) ? PageMax : v;
  endfunction

  assign q_pop_o  = q_valid_i && (!out_valid_q || res_o.ready);
  assign arg      = q_head_i.arg;
  assign col_end  = (col_ptr_q == col_last_q) || (col_ptr_q >= ColMax);
  assign page_end = (page_ptr_q == page_last_q) || (page_ptr_q >= PageMax);
  assign col_inc  = col_ptr_q + 7'd1;
  assign page_inc = page_ptr_q + 3'd1;

  always_comb begin
    mode_d       = mode_q;
    col_first_d  = col_first_q;
    col_last_d   = col_last_q;
    col_ptr_d    = col_ptr_q;
    page_first_d = page_first_q;
    page_last_d  = page_last_q;
    page_ptr_d   = page_ptr_q;
    contrast_d   = contrast_q;
    on_d         = on_q;
    invert_d     = invert_q;
    lit_d        = lit_q;
    remap_d      = remap_q;
    scan_d       = scan_q;
    start_d      = start_q;
    timing_we    = 1'b0;
    wres_d       = '0;

    unique case (q_head_i.op)
      OP_DATA: begin
        wres_d.ram_write  = 1'b1;
        wres_d.ram_page   = page_ptr_q;
        wres_d.ram_column = col_ptr_q;
        wres_d.ram_data   = arg;
        unique case (mode_q)
          MODE_HORIZONTAL: begin
            if (col_end) begin
              col_ptr_d  = col_first_q;
              page_ptr_d = page_end ? page_first_q : page_inc;
            end else begin
              col_ptr_d = col_inc;
            end
          end
          MODE_VERTICAL: begin
            if (page_end) begin
              page_ptr_d = page_first_q;
              col_ptr_d  = col_end ? col_first_q : col_inc;
            end else begin
              page_ptr_d = page_inc;
            end
          end
          default: begin
            col_ptr_d = (col_ptr_q >= ColMax) ? 7'd0 : col_inc;
          end
        endcase
      end
      OP_COL_LO:         col_ptr_d  = clamp_col({col_ptr_q[6:4], arg[3:0]});
      OP_COL_HI:         col_ptr_d  = clamp_col({arg[2:0], col_ptr_q[3:0]});
      OP_START_LINE:     start_d    = arg[5:0];
      OP_REMAP:          remap_d    = arg[0];
      OP_ALL_LIT:        lit_d      = arg[0];
      OP_INVERT:         invert_d   = arg[0];
      OP_DISPLAY:        on_d       = arg[0];
      OP_PAGE_SET:       page_ptr_d = clamp_page(arg[2:0]);
      OP_SCAN:           scan_d     = arg[3];
      OP_BAD:            wres_d.bad_opcode = 1'b1;
      OP_ARG_MODE: begin
        if (arg[1:0] != MODE_RESERVED) begin
          mode_d = arg[1:0];
        end
      end
      OP_ARG_COL_FIRST:  col_first_d = clamp_col(arg[6:0]);
      OP_ARG_COL_LAST: begin
        col_last_d = clamp_col(arg[6:0]);
        col_ptr_d  = col_first_q;
      end
      OP_ARG_PAGE_FIRST: page_first_d = clamp_page(arg[2:0]);
      OP_ARG_PAGE_LAST: begin
        page_last_d = clamp_page(arg[2:0]);
        page_ptr_d  = page_first_q;
      end
      OP_ARG_CONTRAST:   contrast_d = arg;
      OP_ARG_TIMING:     timing_we  = 1'b1;
      default:           wres_d     = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_PAGE;
      col_first_q  <= '0;
      col_last_q   <= ColMax;
      col_ptr_q    <= '0;
      page_first_q <= '0;
      page_last_q  <= PageMax;
      page_ptr_q   <= '0;
      contrast_q   <= CONTRAST_RESET;
      on_q         <= 1'b0;
      invert_q     <= 1'b0;
      lit_q        <= 1'b0;
      remap_q      <= 1'b0;
      scan_q       <= 1'b0;
      start_q      <= '0;
      for (int i = 0; i < TIMING_SLOTS; i++) begin
        timing_q[i] <= TIMING_RESET[i];
      end
      out_valid_q  <= 1'b0;
    end else begin
      if (q_pop_o) begin
        mode_q       <= mode_d;
        col_first_q  <= col_first_d;
        col_last_q   <= col_last_d;
        col_ptr_q    <= col_ptr_d;
        page_first_q <= page_first_d;
        page_last_q  <= page_last_d;
        page_ptr_q   <= page_ptr_d;
        contrast_q   <= contrast_d;
        on_q         <= on_d;
        invert_q     <= invert_d;
        lit_q        <= lit_d;
        remap_q      <= remap_d;
        scan_q       <= scan_d;
        start_q      <= start_d;
        if (timing_we && (q_head_i.slot < 3'(TIMING_SLOTS))) begin
          timing_q[q_head_i.slot] <= arg;
        end
        out_valid_q  <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      wres_q <= wres_d;
    end
  end

  // Settings fields come straight from the state registers, which are updated
  // together with the result register.
  assign res_o.valid          = out_valid_q;
  assign res_o.ram_write      = wres_q.ram_write;
  assign res_o.ram_page       = wres_q.ram_page;
  assign res_o.ram_column     = wres_q.ram_column;
  assign res_o.ram_data       = wres_q.ram_data;
  assign res_o.bad_opcode     = wres_q.bad_opcode;
  assign res_o.panel_on       = on_q;
  assign res_o.invert_pixels  = invert_q;
  assign res_o.all_pixels_lit = lit_q;
  assign res_o.contrast_level = contrast_q;
  assign res_o.first_line     = start_q;
  assign res_o.mirror_columns = remap_q;
  assign res_o.scan_reversed  = scan_q;

  `OCD_ASSERT(a_ptr_range, (col_ptr_q <= ColMax) && (page_ptr_q <= PageMax),
              "address pointer beyond the panel")
  `OCD_ASSERT(a_window_range, (col_last_q <= ColMax) && (page_last_q <= PageMax),
              "window end beyond the panel")
  `OCD_ASSERT(a_mode_legal, mode_q != MODE_RESERVED, "reserved addressing mode stored")
  `OCD_ASSERT_IMPL(a_timing_slot, q_pop_o && timing_we,
                   q_head_i.slot < 3'(TIMING_SLOTS) && timing_q[0] == timing_q[0],
                   "timing write to a slot that does not exist")

endmodule

@@ rtl/core/oled_command_decoder.sv @@
// OLED command decoder. Takes one host byte per transaction on cmd_i, marked as
// a command (kind 0) or display data (kind 1), and returns exactly one result
// transaction on res_o per byte, in order. A data byte yields a RAM write at the
// current page and column and then advances the pointer in the selected
// addressing mode; command bytes update the stored settings, with argument
// bytes gathered for the commands that take them. The decoder sustains one
// transaction per clock while res_o is ready: the front end classifies a byte
// in the cycle it is accepted, a two-entry queue holds it, and the back end
// executes it and registers the result, so a byte passes the queue register
// and then the output register before its result shows on res_o.
// Back-pressure on res_o fills the queue before cmd_i.ready drops.
// Depends on ocd_pkg, ocd_cmd_if, ocd_res_if, ocd_queue, ocd_front and ocd_back.
`timescale 1ns / 1ps

module oled_command_decoder #(
  parameter int unsigned COLUMNS = ocd_pkg::COLUMNS_DFLT,
  parameter int unsigned PAGES   = ocd_pkg::PAGES_DFLT
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ocd_cmd_if.sink   cmd_i,
  ocd_res_if.source res_o
);
  import ocd_pkg::*;

  // Classified operations travel from the front end to the back end here.
  op_entry_t push_entry, head_entry;
  logic      push, q_full, q_valid, q_pop;

  // The front end owns the argument tracking, since it depends only on the
  // byte sequence and not on the executed state.
  ocd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .push_entry_o (push_entry)
  );

  ocd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (q_full),
    .pop_i        (q_pop),
    .valid_o      (q_valid),
    .head_o       (head_entry)
  );

  // The back end holds the pointers, windows and panel settings and the
  // output register.
  ocd_back #(
    .COLUMNS (COLUMNS),
    .PAGES   (PAGES)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_valid_i (q_valid),
    .q_head_i  (head_entry),
    .q_pop_o   (q_pop),
    .res_o     (res_o)
  );

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for oled_command_decoder: drives host command and data
// bytes on cmd_i and checks every result transaction on res_o against a predictor.
// Depends on ocd_pkg, ocd_cmd_if, ocd_res_if and the decoder RTL.
`timescale 1ns / 1ps

module tb_top;
  import ocd_pkg::*;

  localparam int unsigned CLK_PERIOD     = 10;
  localparam int unsigned RESET_CYCLES   = 9;
  localparam int unsigned COLUMNS        = COLUMNS_DFLT;
  localparam int unsigned PAGES          = PAGES_DFLT;
  localparam int unsigned RANDOM_BYTES   = 1150;
  localparam int unsigned DIRECTED_ROWS  = 25;
  // The sender holds off at this byte until every result has come back.
  localparam int unsigned DRAIN_AT       = 600;
  // The receiver stops taking results for a long stretch once this many came.
  localparam int unsigned HOLD_AFTER     = 150;
  localparam int unsigned HOLD_CYCLES    = 80;
  // Time after the last result for a stray one to show up, with plenty of margin.
  localparam int unsigned SETTLE_CYCLES  = 16;
  localparam int unsigned TIMEOUT_CYCLES = 200_000;
  localparam int unsigned MAX_REPORTS    = 40;

  // DC line values.
  localparam logic KIND_CMD  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  // Opcodes that the package does not name.
  localparam logic [7:0] OPC_COL_LO_BASE = 8'h00;
  localparam logic [7:0] OPC_COL_HI_BASE = 8'h10;
  localparam logic [7:0] OPC_START_BASE  = 8'h40;
  localparam logic [7:0] OPC_REMAP_OFF   = 8'hA0;
  localparam logic [7:0] OPC_REMAP_ON    = 8'hA1;
  localparam logic [7:0] OPC_FOLLOW_RAM  = 8'hA4;
  localparam logic [7:0] OPC_ALL_ON      = 8'hA5;
  localparam logic [7:0] OPC_NORMAL      = 8'hA6;
  localparam logic [7:0] OPC_INVERSE     = 8'hA7;
  localparam logic [7:0] OPC_DISPLAY_OFF = 8'hAE;
  localparam logic [7:0] OPC_DISPLAY_ON  = 8'hAF;
  localparam logic [7:0] OPC_PAGE_BASE   = 8'hB0;
  localparam logic [7:0] OPC_SCAN_BASE   = 8'hC0;
  localparam logic [7:0] OPC_SCAN_REV    = 8'hC8;
  // Two opcodes that the decoder must reject: the top code and the first page
  // code beyond the last page.
  localparam logic [7:0] BAD_OPC_TOP     = 8'hFF;
  localparam logic [7:0] BAD_OPC_PAGE    = 8'hB8;

  localparam logic [7:0] TIMING_OPCODES [TIMING_SLOTS] =
    '{OPC_MUX, OPC_OFFSET, OPC_CLOCK, OPC_PRECHARGE, OPC_COM_PINS, OPC_VCOMH, OPC_PUMP};
  localparam logic [7:0] FLAG_OPCODES [9] =
    '{OPC_REMAP_OFF, OPC_REMAP_ON, OPC_FOLLOW_RAM, OPC_ALL_ON, OPC_NORMAL, OPC_INVERSE,
      OPC_DISPLAY_OFF, OPC_DISPLAY_ON, OPC_NOP};

  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY} stall_style_e;

  // One result transaction, in the order of the fields on res_o.
  typedef struct packed {
    logic       ram_write;
    logic [2:0] ram_page;
    logic [6:0] ram_column;
    logic [7:0] ram_data;
    logic       panel_on;
    logic       invert_pixels;
    logic       all_pixels_lit;
    logic [7:0] contrast_level;
    logic [5:0] first_line;
    logic       mirror_columns;
    logic       scan_reversed;
    logic       bad_opcode;
  } panel_result_t;

  // One host byte. When pinned is set, the result is the typed-in one below
  // instead of the predicted one.
  typedef struct packed {
    logic          kind;
    logic [7:0]    bus_byte;
    logic          pinned;
    panel_result_t want;
  } host_byte_t;

  // Directed opening. The first rows start from the reset state, so their
  // results are plain to read; the rest go through the predictor. The column
  // window 126..5 has its start above its end, and the data bytes after it
  // show the horizontal wrap to the window start with a page step.
  localparam host_byte_t DIRECTED [DIRECTED_ROWS] = '{
    '{KIND_DATA, 8'hFF, 1'b1, '{1'b1, 3'd0, 7'd0, 8'hFF, 1'b0, 1'b0, 1'b0, 8'h7F, 6'd0,
                                1'b0, 1'b0, 1'b0}},
    '{KIND_DATA, 8'h00, 1'b1, '{1'b1, 3'd0, 7'd1, 8'h00, 1'b0, 1'b0, 1'b0, 8'h7F, 6'd0,
                                1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_DISPLAY_ON, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b0, 1'b0, 8'h7F,
                                        6'd0, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_INVERSE, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b0, 8'h7F,
                                     6'd0, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_ALL_ON, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h7F,
                                    6'd0, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_CONTRAST, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h7F,
                                      6'd0, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, 8'h00, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                               6'd0, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, 8'h7F, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                               6'd63, 1'b0, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_REMAP_ON, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                                      6'd63, 1'b1, 1'b0, 1'b0}},
    '{KIND_CMD, OPC_SCAN_REV, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                                      6'd63, 1'b1, 1'b1, 1'b0}},
    '{KIND_CMD, BAD_OPC_TOP, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                                     6'd63, 1'b1, 1'b1, 1'b1}},
    '{KIND_CMD, BAD_OPC_PAGE, 1'b1, '{1'b0, 3'd0, 7'd0, 8'h00, 1'b1, 1'b1, 1'b1, 8'h00,
                                      6'd63, 1'b1, 1'b1, 1'b1}},
    '{KIND_CMD, OPC_ADDR_MODE, 1'b0, '0},
    '{KIND_CMD, {6'd0, MODE_RESERVED}, 1'b0, '0},
    '{KIND_CMD, OPC_COL_WINDOW, 1'b0, '0},
    '{KIND_CMD, 8'h7E, 1'b0, '0},
    '{KIND_CMD, 8'h05, 1'b0, '0},
    '{KIND_CMD, OPC_ADDR_MODE, 1'b0, '0},
    '{KIND_CMD, {6'd0, MODE_HORIZONTAL}, 1'b0, '0},
    '{KIND_DATA, 8'h55, 1'b0, '0},
    '{KIND_DATA, 8'hAA, 1'b0, '0},
    '{KIND_CMD, OPC_PAGE_WINDOW, 1'b0, '0},
    '{KIND_DATA, 8'h80, 1'b0, '0},
    '{KIND_CMD, OPC_NOP, 1'b0, '0},
    '{KIND_CMD, OPC_COL_LO_BASE | 8'h0F, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni;

  ocd_cmd_if host_if ();
  ocd_res_if panel_if ();

  oled_command_decoder i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (host_if),
    .res_o  (panel_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  host_byte_t    host_bytes[$];
  panel_result_t pending_results[$];
  int unsigned   sent_count = 0;
  int unsigned   mismatches = 0;

  // ---------------------------------------------------------------------------
  // Predictor state: the decoder's pointer, windows and panel settings as the
  // host has programmed them so far.
  // ---------------------------------------------------------------------------
  logic [7:0] arg_opcode;
  logic [1:0] args_pending;
  logic [1:0] addr_mode;
  logic [6:0] win_col_first, win_col_last, cur_column;
  logic [2:0] win_page_first, win_page_last, cur_page;
  logic [7:0] contrast;
  logic       lit_on, inverted, forced_on, remapped, scan_rev;
  logic [5:0] start_line;
  logic [7:0] timing_regs [TIMING_SLOTS];

  function automatic logic [6:0] sat_column(input logic [7:0] v);
    return (v[6:0] > COLUMNS - 1) ? 7'(COLUMNS - 1) : v[6:0];
  endfunction

  function automatic logic [2:0] sat_page(input logic [7:0] v);
    return (v[2:0] > PAGES - 1) ? 3'(PAGES - 1) : v[2:0];
  endfunction

  // Column step inside the window; returns 1 when it wrapped to the start.
  function automatic logic bump_column();
    if (cur_column == win_col_last || cur_column >= COLUMNS - 1) begin
      cur_column = win_col_first;
      return 1'b1;
    end
    cur_column = cur_column + 7'd1;
    return 1'b0;
  endfunction

  function automatic logic bump_page();
    if (cur_page == win_page_last || cur_page >= PAGES - 1) begin
      cur_page = win_page_first;
      return 1'b1;
    end
    cur_page = cur_page + 3'd1;
    return 1'b0;
  endfunction

  function automatic void reset_panel_model();
    arg_opcode     = '0;
    args_pending   = '0;
    addr_mode      = MODE_PAGE;
    win_col_first  = '0;
    win_col_last   = sat_column(8'd127);
    win_page_first = '0;
    win_page_last  = sat_page(8'd7);
    cur_column     = '0;
    cur_page       = '0;
    contrast       = CONTRAST_RESET;
    {lit_on, inverted, forced_on, remapped, scan_rev} = '0;
    start_line     = '0;
    for (int i = 0; i < TIMING_SLOTS; i++) timing_regs[i] = TIMING_RESET[i];
  endfunction

  // Applies one host byte to the model and returns the result it must cause.
  function automatic panel_result_t predict_panel(input logic kind, input logic [7:0] b);
    panel_result_t r;
    logic          last_arg;
    r = '0;
    if (kind == KIND_DATA) begin
      // A data byte drops any command still waiting for arguments.
      args_pending = '0;
      r.ram_write  = 1'b1;
      r.ram_page   = cur_page;
      r.ram_column = cur_column;
      r.ram_data   = b;
      case (addr_mode)
        MODE_HORIZONTAL: if (bump_column()) void'(bump_page());
        MODE_VERTICAL:   if (bump_page()) void'(bump_column());
        default:         cur_column = (cur_column >= COLUMNS - 1) ? 7'd0 : cur_column + 7'd1;
      endcase
    end else if (args_pending != 0) begin
      last_arg     = (args_pending == 2'd1);
      args_pending = args_pending - 2'd1;
      case (arg_opcode)
        OPC_ADDR_MODE: if (b[1:0] != MODE_RESERVED) addr_mode = b[1:0];
        OPC_COL_WINDOW: begin
          if (!last_arg) win_col_first = sat_column(b);
          else begin
            win_col_last = sat_column(b);
            cur_column   = win_col_first;
          end
        end
        OPC_PAGE_WINDOW: begin
          if (!last_arg) win_page_first = sat_page(b);
          else begin
            win_page_last = sat_page(b);
            cur_page      = win_page_first;
          end
        end
        OPC_CONTRAST:  contrast = b;
        OPC_MUX:       timing_regs[SLOT_MUX] = b;
        OPC_OFFSET:    timing_regs[SLOT_OFFSET] = b;
        OPC_CLOCK:     timing_regs[SLOT_CLOCK] = b;
        OPC_PRECHARGE: timing_regs[SLOT_PRECHARGE] = b;
        OPC_COM_PINS:  timing_regs[SLOT_COM_PINS] = b;
        OPC_VCOMH:     timing_regs[SLOT_VCOMH] = b;
        OPC_PUMP:      timing_regs[SLOT_PUMP] = b;
        default: ;
      endcase
    end else if (b[7:4] == OPC_COL_LO_BASE[7:4]) begin
      cur_column = sat_column({1'b0, cur_column[6:4], b[3:0]});
    end else if (b[7:4] == OPC_COL_HI_BASE[7:4]) begin
      cur_column = sat_column({1'b0, b[2:0], cur_column[3:0]});
    end else if (b == OPC_COL_WINDOW || b == OPC_PAGE_WINDOW) begin
      arg_opcode   = b;
      args_pending = 2'd2;
    end else if (b == OPC_ADDR_MODE || b == OPC_CONTRAST ||
                 b inside {OPC_MUX, OPC_OFFSET, OPC_CLOCK, OPC_PRECHARGE,
                           OPC_COM_PINS, OPC_VCOMH, OPC_PUMP}) begin
      arg_opcode   = b;
      args_pending = 2'd1;
    end else if (b[7:6] == OPC_START_BASE[7:6]) begin
      start_line = b[5:0];
    end else if (b == OPC_REMAP_OFF || b == OPC_REMAP_ON) begin
      remapped = b[0];
    end else if (b == OPC_FOLLOW_RAM || b == OPC_ALL_ON) begin
      forced_on = b[0];
    end else if (b == OPC_NORMAL || b == OPC_INVERSE) begin
      inverted = b[0];
    end else if (b == OPC_DISPLAY_OFF || b == OPC_DISPLAY_ON) begin
      lit_on = b[0];
    end else if (b[7:3] == OPC_PAGE_BASE[7:3]) begin
      cur_page = sat_page(b);
    end else if (b[7:4] == OPC_SCAN_BASE[7:4]) begin
      scan_rev = b[3];
    end else if (b != OPC_NOP) begin
      r.bad_opcode = 1'b1;
    end
    // The settings fields always show the state after the byte.
    r.panel_on       = lit_on;
    r.invert_pixels  = inverted;
    r.all_pixels_lit = forced_on;
    r.contrast_level = contrast;
    r.first_line     = start_line;
    r.mirror_columns = remapped;
    r.scan_reversed  = scan_rev;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking. Reports are capped so that a broken build does not flood the log;
  // every mismatch is still counted.
  // ---------------------------------------------------------------------------
  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      if (mismatches < MAX_REPORTS)
        $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, want, got);
      mismatches++;
    end
  endtask

  task automatic check_result(input panel_result_t want, input panel_result_t got);
    check_field("ram_write", 8'(want.ram_write), 8'(got.ram_write));
    check_field("ram_page", 8'(want.ram_page), 8'(got.ram_page));
    check_field("ram_column", 8'(want.ram_column), 8'(got.ram_column));
    check_field("ram_data", want.ram_data, got.ram_data);
    check_field("panel_on", 8'(want.panel_on), 8'(got.panel_on));
    check_field("invert_pixels", 8'(want.invert_pixels), 8'(got.invert_pixels));
    check_field("all_pixels_lit", 8'(want.all_pixels_lit), 8'(got.all_pixels_lit));
    check_field("contrast_level", want.contrast_level, got.contrast_level);
    check_field("first_line", 8'(want.first_line), 8'(got.first_line));
    check_field("mirror_columns", 8'(want.mirror_columns), 8'(got.mirror_columns));
    check_field("scan_reversed", 8'(want.scan_reversed), 8'(got.scan_reversed));
    check_field("bad_opcode", 8'(want.bad_opcode), 8'(got.bad_opcode));
  endtask

  // ---------------------------------------------------------------------------
  // Stimulus. The random part is mostly well-formed command sequences with
  // random arguments and bursts of display data, so that windows, modes and
  // pointer wraps are reached; a smaller share is truncated argument sequences
  // and arbitrary command bytes.
  // ---------------------------------------------------------------------------
  task automatic push_byte(input logic kind, input logic [7:0] b);
    host_byte_t item;
    item = '0;
    item.kind     = kind;
    item.bus_byte = b;
    host_bytes.push_back(item);
  endtask

  task automatic build_random_traffic();
    int unsigned pick, n, first, last;
    while (host_bytes.size() < DIRECTED_ROWS + RANDOM_BYTES) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        // Mostly short bursts; now and then a long one, up to 140 bytes, that can cross a full row.
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 140) : $urandom_range(1, 20);
        repeat (n) push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
      end else if (pick < 45) begin
        push_byte(KIND_CMD, OPC_COL_LO_BASE | 8'($urandom_range(0, 15)));
        if ($urandom_range(0, 1)) push_byte(KIND_CMD, OPC_COL_HI_BASE | 8'($urandom_range(0, 15)));
      end else if (pick < 52) begin
        push_byte(KIND_CMD, OPC_PAGE_BASE | 8'($urandom_range(0, 7)));
      end else if (pick < 62) begin
        case ($urandom_range(0, 2))
          0:       push_byte(KIND_CMD, FLAG_OPCODES[$urandom_range(0, 8)]);
          1:       push_byte(KIND_CMD, OPC_START_BASE | 8'($urandom_range(0, 63)));
          default: push_byte(KIND_CMD, OPC_SCAN_BASE | 8'($urandom_range(0, 15)));
        endcase
      end else if (pick < 70) begin
        push_byte(KIND_CMD, OPC_ADDR_MODE);
        push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
      end else if (pick < 78) begin
        // Column window: mostly narrow so the wrap shows up, sometimes arbitrary.
        first = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 127);
        last  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255)
              : (first[6:0] + $urandom_range(0, 10) > 127 ? 127 : first[6:0] + $urandom_range(0, 10));
        push_byte(KIND_CMD, OPC_COL_WINDOW);
        push_byte(KIND_CMD, 8'(first));
        push_byte(KIND_CMD, 8'(last));
      end else if (pick < 84) begin
        first = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(0, 7);
        last  = $urandom_range(0, 3) == 0 ? $urandom_range(0, 255) : $urandom_range(first[2:0], 7);
        push_byte(KIND_CMD, OPC_PAGE_WINDOW);
        push_byte(KIND_CMD, 8'(first));
        push_byte(KIND_CMD, 8'(last));
      end else if (pick < 88) begin
        push_byte(KIND_CMD, OPC_CONTRAST);
        push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        push_byte(KIND_CMD, TIMING_OPCODES[$urandom_range(0, TIMING_SLOTS - 1)]);
        push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
      end else if (pick < 96) begin
        // Argument sequence cut short by display data.
        if ($urandom_range(0, 1)) begin
          push_byte(KIND_CMD, $urandom_range(0, 1) ? OPC_COL_WINDOW : OPC_PAGE_WINDOW);
          if ($urandom_range(0, 1)) push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
        end else begin
          push_byte(KIND_CMD, $urandom_range(0, 1) ? OPC_CONTRAST : OPC_ADDR_MODE);
        end
        repeat ($urandom_range(1, 4)) push_byte(KIND_DATA, 8'($urandom_range(0, 255)));
      end else begin
        push_byte(KIND_CMD, 8'($urandom_range(0, 255)));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Host side: records the expected result of every accepted transaction,
  // checks every result transaction, and offers bytes in bursts with gaps.
  // Doing both channels in one process keeps the order of pushes and pops on
  // the expectation queue fixed when both fall due together.
  // ---------------------------------------------------------------------------
  initial begin : host_side
    host_byte_t    item;
    panel_result_t want, got;
    logic          offer, drained;
    int unsigned   burst_left, gap_left;
    drained    = 1'b0;
    burst_left = 0;
    gap_left   = 0;
    host_if.valid    = 1'b0;
    host_if.kind     = KIND_CMD;
    host_if.bus_byte = '0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (host_if.valid && host_if.ready) begin
          item = host_bytes[sent_count];
          want = predict_panel(item.kind, item.bus_byte);
          pending_results.push_back(item.pinned ? item.want : want);
          sent_count++;
        end
        if (panel_if.valid && panel_if.ready) begin
          got = '{panel_if.ram_write, panel_if.ram_page, panel_if.ram_column,
                  panel_if.ram_data, panel_if.panel_on, panel_if.invert_pixels,
                  panel_if.all_pixels_lit, panel_if.contrast_level, panel_if.first_line,
                  panel_if.mirror_columns, panel_if.scan_reversed, panel_if.bad_opcode};
          if (pending_results.size() == 0) begin
            if (mismatches < MAX_REPORTS)
              $display("%0t ns: result expected none, got 0x%0h", $time, got);
            mismatches++;
          end else begin
            check_result(pending_results.pop_front(), got);
          end
        end
        // A byte that is offered stays on the bus until it is taken.
        if (!host_if.valid || host_if.ready) begin
          offer = 1'b0;
          if (sent_count < host_bytes.size()) begin
            if (sent_count == DRAIN_AT && !drained) begin
              // Let the decoder run completely dry once.
              drained = (pending_results.size() == 0);
            end else if (gap_left > 0) begin
              gap_left--;
            end else begin
              offer = 1'b1;
              if (burst_left > 0) burst_left--;
              if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
          end
          host_if.valid <= offer;
          if (offer) begin
            host_if.kind     <= host_bytes[sent_count].kind;
            host_if.bus_byte <= host_bytes[sent_count].bus_byte;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result side: alternates between stretches of always ready, light stalls and
  // heavy stalls, and holds off completely once so that the decoder's queue
  // fills and it pushes back on the host.
  // ---------------------------------------------------------------------------
  initial begin : panel_side
    int unsigned  results_seen, hold_left, phase_left;
    stall_style_e style;
    logic         hold_done, take;
    results_seen = 0;
    hold_left    = 0;
    phase_left   = 0;
    style        = STALL_NONE;
    hold_done    = 1'b0;
    panel_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (panel_if.valid && panel_if.ready) results_seen++;
        if (!hold_done && results_seen >= HOLD_AFTER) begin
          hold_done = 1'b1;
          hold_left = HOLD_CYCLES;
        end
        if (phase_left == 0) begin
          style      = stall_style_e'($urandom_range(0, 2));
          phase_left = $urandom_range(16, 96);
        end
        phase_left--;
        if (hold_left > 0) begin
          hold_left--;
          take = 1'b0;
        end else begin
          case (style)
            STALL_NONE:  take = 1'b1;
            STALL_LIGHT: take = ($urandom_range(0, 3) != 0);
            default:     take = ($urandom_range(0, 3) == 0);
          endcase
        end
        panel_if.ready <= take;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Run control: build the byte stream, reset once, wait for the last result.
  // ---------------------------------------------------------------------------
  initial begin : run_control
    rst_ni = 1'b0;
    reset_panel_model();
    for (int i = 0; i < DIRECTED_ROWS; i++) host_bytes.push_back(DIRECTED[i]);
    build_random_traffic();
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    while (sent_count < host_bytes.size() || pending_results.size() != 0) @(posedge clk_i);
    // Anything that still shows up now is a result nobody asked for.
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin : watchdog
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
